// ===== src/cfcb_pkg.sv =====
// ----------------------------------------------------------------------------
// cfcb_pkg
// Shared constants, queue entry type and CRC-16 byte update for the
// command frame builder.
// ----------------------------------------------------------------------------
package cfcb_pkg;

    localparam int MAX_CMD_BYTES = 16;
    localparam int BYTE_W        = 8;
    localparam int CRC_W         = 16;

    // Remaining-byte counter only has to hold MAX_CMD_BYTES-6 at most.
    localparam int LEN_W = $clog2(MAX_CMD_BYTES - 4);

    localparam logic [BYTE_W-1:0] LEN_MAX      = BYTE_W'(MAX_CMD_BYTES - 5);
    localparam logic [BYTE_W-1:0] MARKER_BYTE  = 8'hC0;
    localparam logic [BYTE_W-1:0] HDR_LEN_MASK = 8'h0F;
    localparam logic [CRC_W-1:0]  CRC_POLY     = 16'h8408;
    localparam logic [CRC_W-1:0]  CRC_INIT     = 16'hFFFF;
    localparam int                CRC_EN_BIT   = 6;

    // Request queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Status codes on the packet channel.
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_BAD_LEN = 1'b1;

    // Request kinds handed from the front to the back.
    localparam logic [1:0] K_ERR   = 2'd0;   // bad length, single error result
    localparam logic [1:0] K_FIRST = 2'd1;   // opens a packet: marker + header first
    localparam logic [1:0] K_DATA  = 2'd2;   // command byte inside an open packet

    typedef struct packed {
        logic [1:0]        kind;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] hdr;
        logic              is_final;
        logic              crc_on;
    } t_entry;

    typedef struct packed {
        logic busy;        // back is partway through a multi-byte request
        logic crc_at_init; // running CRC equals its initial value
    } t_back_stat;

    // Reflected CRC-16, one byte per call (eight narrow dependent steps).
    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== src/cfcb_cmd_if.sv =====
// ----------------------------------------------------------------------------
// cfcb_cmd_if
// Command byte channel: valid/ready with byte, control and length.
// ----------------------------------------------------------------------------
interface cfcb_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [cfcb_pkg::BYTE_W-1:0] cmd_byte;
    logic [cfcb_pkg::BYTE_W-1:0] ctrl;
    logic [cfcb_pkg::BYTE_W-1:0] cmd_length;

    modport source (output valid, output cmd_byte, output ctrl, output cmd_length,
                    input ready);
    modport sink   (input valid, input cmd_byte, input ctrl, input cmd_length,
                    output ready);
endinterface

// ===== src/cfcb_pkt_if.sv =====
// ----------------------------------------------------------------------------
// cfcb_pkt_if
// Packet byte channel: valid/ready with byte, last flag and status.
// ----------------------------------------------------------------------------
interface cfcb_pkt_if;
    logic                       valid;
    logic                       ready;
    logic [cfcb_pkg::BYTE_W-1:0] out_byte;
    logic                       last;
    logic                       status;

    modport source (output valid, output out_byte, output last, output status,
                    input ready);
    modport sink   (input valid, input out_byte, input last, input status,
                    output ready);
endinterface

// ===== src/cfcb_front.sv =====
// ----------------------------------------------------------------------------
// cfcb_front
// Accepts command bytes, checks length, tracks packet position and
// classifies each request for the back.
// ----------------------------------------------------------------------------
module cfcb_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    cfcb_cmd_if.sink         i_cmd,
    output logic             o_q_valid,
    input  logic             i_q_ready,
    output cfcb_pkg::t_entry o_q_entry
);
    import cfcb_pkg::*;

    logic             r_in_packet, n_in_packet;
    logic [LEN_W-1:0] r_left, n_left;
    logic             r_crc_on, n_crc_on;
    logic             len_bad;
    logic             accept;
    t_entry           entry;

    assign len_bad = (i_cmd.cmd_length == '0) || (i_cmd.cmd_length > LEN_MAX);
    assign accept  = i_cmd.valid && i_q_ready;

    always_comb begin
        n_in_packet    = r_in_packet;
        n_left         = r_left;
        n_crc_on       = r_crc_on;
        entry.data     = i_cmd.cmd_byte;
        entry.hdr      = i_cmd.ctrl | (i_cmd.cmd_length & HDR_LEN_MASK);
        entry.kind     = K_DATA;
        entry.is_final = 1'b0;
        entry.crc_on   = r_crc_on;
        if (!r_in_packet) begin
            if (len_bad) begin
                entry.kind = K_ERR;
            end else begin
                entry.kind     = K_FIRST;
                entry.crc_on   = i_cmd.ctrl[CRC_EN_BIT];
                entry.is_final = (i_cmd.cmd_length == 8'd1);
                n_crc_on       = i_cmd.ctrl[CRC_EN_BIT];
                n_left         = LEN_W'(i_cmd.cmd_length - 8'd1);
                n_in_packet    = (i_cmd.cmd_length != 8'd1);
            end
        end else begin
            entry.is_final = (r_left == LEN_W'(1));
            n_left         = r_left - LEN_W'(1);
            n_in_packet    = (r_left != LEN_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_packet <= 1'b0;
            r_left      <= '0;
            r_crc_on    <= 1'b0;
        end else if (accept) begin
            r_in_packet <= n_in_packet;
            r_left      <= n_left;
            r_crc_on    <= n_crc_on;
        end
    end

    assign i_cmd.ready = i_q_ready;
    assign o_q_valid   = i_cmd.valid;
    assign o_q_entry   = entry;

endmodule

// ===== src/cfcb_queue.sv =====
// ----------------------------------------------------------------------------
// cfcb_queue
// Two-entry request queue between front and back.
// ----------------------------------------------------------------------------
module cfcb_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  cfcb_pkg::t_entry i_push_entry,
    output logic             o_pop_valid,
    input  logic             i_pop,
    output cfcb_pkg::t_entry o_pop_entry
);
    import cfcb_pkg::*;

    t_entry             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               push, pop;

    assign o_push_ready = (r_count != Q_CNT_W'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;
    assign o_pop_entry  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                : r_wr_ptr + Q_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                : r_rd_ptr + Q_PTR_W'(1);
            end
            r_count <= r_count + Q_CNT_W'(push) - Q_CNT_W'(pop);
        end
    end

endmodule

// ===== src/cfcb_back.sv =====
// ----------------------------------------------------------------------------
// cfcb_back
// Expands queued requests into packet bytes, runs the CRC and drives the
// registered output channel.
// ----------------------------------------------------------------------------
module cfcb_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  cfcb_pkg::t_entry   i_q_entry,
    output logic               o_q_pop,
    cfcb_pkt_if.source         o_pkt,
    output cfcb_pkg::t_back_stat o_stat
);
    import cfcb_pkg::*;

    localparam logic [2:0] P_ERR  = 3'd0;
    localparam logic [2:0] P_MARK = 3'd1;
    localparam logic [2:0] P_HDR  = 3'd2;
    localparam logic [2:0] P_DATA = 3'd3;
    localparam logic [2:0] P_CRCL = 3'd4;
    localparam logic [2:0] P_CRCH = 3'd5;

    logic [2:0]        r_phase, n_phase;
    logic              r_busy, n_busy;
    logic [CRC_W-1:0]  r_crc, n_crc;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic              r_out_last, n_out_last;
    logic              r_out_status, n_out_status;
    logic [2:0]        cur_phase;
    logic              fire, pop;

    // Output register can take a byte when empty or being drained.
    assign fire = i_q_valid && (!r_out_valid || o_pkt.ready);

    always_comb begin
        if (r_busy) begin
            cur_phase = r_phase;
        end else if (i_q_entry.kind == K_FIRST) begin
            cur_phase = P_MARK;
        end else if (i_q_entry.kind == K_DATA) begin
            cur_phase = P_DATA;
        end else begin
            cur_phase = P_ERR;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_busy       = r_busy;
        n_crc        = r_crc;
        n_out_byte   = '0;
        n_out_last   = 1'b0;
        n_out_status = ST_OK;
        pop          = 1'b0;
        unique case (cur_phase)
            P_ERR: begin
                n_out_last   = 1'b1;
                n_out_status = ST_BAD_LEN;
                n_busy       = 1'b0;
                pop          = 1'b1;
            end
            P_MARK: begin
                n_out_byte = MARKER_BYTE;
                n_crc      = crc_feed(r_crc, MARKER_BYTE);
                n_phase    = P_HDR;
                n_busy     = 1'b1;
            end
            P_HDR: begin
                n_out_byte = i_q_entry.hdr;
                n_crc      = crc_feed(r_crc, i_q_entry.hdr);
                n_phase    = P_DATA;
                n_busy     = 1'b1;
            end
            P_DATA: begin
                n_out_byte = i_q_entry.data;
                n_crc      = crc_feed(r_crc, i_q_entry.data);
                n_out_last = i_q_entry.is_final && !i_q_entry.crc_on;
                if (i_q_entry.is_final && i_q_entry.crc_on) begin
                    n_phase = P_CRCL;
                    n_busy  = 1'b1;
                end else begin
                    n_busy = 1'b0;
                    pop    = 1'b1;
                    if (i_q_entry.is_final) begin
                        n_crc = CRC_INIT;
                    end
                end
            end
            P_CRCL: begin
                n_out_byte = r_crc[BYTE_W-1:0];
                n_phase    = P_CRCH;
                n_busy     = 1'b1;
            end
            P_CRCH: begin
                n_out_byte = r_crc[CRC_W-1:BYTE_W];
                n_out_last = 1'b1;
                n_crc      = CRC_INIT;
                n_busy     = 1'b0;
                pop        = 1'b1;
            end
            default: begin
                n_busy = 1'b0;
                pop    = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= P_ERR;
            r_busy      <= 1'b0;
            r_crc       <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_phase <= n_phase;
                r_busy  <= n_busy;
                r_crc   <= n_crc;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_pkt.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_byte   <= n_out_byte;
            r_out_last   <= n_out_last;
            r_out_status <= n_out_status;
        end
    end

    assign o_q_pop          = fire && pop;
    assign o_pkt.valid      = r_out_valid;
    assign o_pkt.out_byte   = r_out_byte;
    assign o_pkt.last       = r_out_last;
    assign o_pkt.status     = r_out_status;
    assign o_stat.busy        = r_busy;
    assign o_stat.crc_at_init = (r_crc == CRC_INIT);

endmodule

// ===== src/command_frame_crc16_builder_top.sv =====
// ----------------------------------------------------------------------------
// command_frame_crc16_builder_top
// Serial command packet builder with CRC-16/MCRF4XX trailer.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd  : command bytes, one request per byte. ctrl and cmd_length are read
//            only on the first byte of a command (length 1..MAX_CMD_BYTES-5).
//   o_pkt  : packet bytes. A packet is 0xC0, header (ctrl | len[3:0]), the
//            command bytes, then CRC low/high when ctrl bit 6 is set. last
//            marks the final byte. A bad length gives one byte 0x00 with
//            last=1, status=1, and the command byte is dropped.
// Path: the request is written to the queue when it is accepted, and the
//   output register loads from the queue head when it can take a byte;
//   o_pkt is driven straight from that register.
// Throughput: one output byte per cycle while o_pkt.ready is high. Inside
//   a packet a command byte is taken every cycle while the queue has room;
//   the first byte becomes marker, header and data; a final byte with CRC
//   becomes data, CRC low, CRC high. The output channel's one-byte-per-cycle
//   register sets the sustained rate; two-entry queue absorbs short bursts.
// Reset: synchronous, active low; clears the queue, the output valid, packet
//   tracking, and returns the CRC to 0xFFFF.
// Stall: when o_pkt.ready is low the output byte holds; the queue keeps
//   taking requests until its two entries are full, then i_cmd.ready drops.
// ----------------------------------------------------------------------------
module command_frame_crc16_builder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cfcb_cmd_if.sink   i_cmd,
    cfcb_pkt_if.source o_pkt
);
    import cfcb_pkg::*;

    // front -> queue
    logic       fq_valid, fq_ready;
    t_entry     fq_entry;
    // queue -> back
    logic       qb_valid, qb_pop;
    t_entry     qb_entry;
    t_back_stat back_stat;

    // Classifies requests and tracks where we are in the packet.
    cfcb_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .o_q_valid (fq_valid),
        .i_q_ready (fq_ready),
        .o_q_entry (fq_entry)
    );

    // Decouples input acceptance from byte insertion at the output.
    cfcb_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fq_valid),
        .o_push_ready (fq_ready),
        .i_push_entry (fq_entry),
        .o_pop_valid  (qb_valid),
        .i_pop        (qb_pop),
        .o_pop_entry  (qb_entry)
    );

    // Emits marker/header/data/CRC and error bytes and owns the running CRC.
    cfcb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (qb_valid),
        .i_q_entry (qb_entry),
        .o_q_pop   (qb_pop),
        .o_pkt     (o_pkt),
        .o_stat    (back_stat)
    );

`ifndef SYNTH
    // Error results are always a lone zero byte closing the request.
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pkt.valid && o_pkt.status) |-> (o_pkt.last && (o_pkt.out_byte == '0)))
        else $error("error result without last or with nonzero byte");

    // Nothing comes out right after reset.
    a_rst_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> (!o_pkt.valid && !back_stat.busy))
        else $error("output active right after reset");

    // A packet about to open must start from a fresh CRC.
    a_crc_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (qb_valid && !back_stat.busy && (qb_entry.kind == K_FIRST))
            |-> back_stat.crc_at_init)
        else $error("CRC not reinitialized at packet start");
`endif

endmodule

// ===== dv/command_frame_crc16_builder_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_frame_crc16_builder_top_tb
// Drives command bytes into the frame builder with bursty requests and a
// stalling packet sink. A local frame predictor queues the expected packet
// bytes; each output byte is checked against the oldest entry.
// ----------------------------------------------------------------------------
module command_frame_crc16_builder_top_tb;

    import cfcb_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 90;
    // Watchdog limit; stays far above the length of the slowest run.
    localparam int CYCLE_LIMIT  = 200000;
    // Covers the output register and the queue, plus margin to catch stray bytes.
    localparam int DRAIN_CYCLES = 12;
    localparam int PRINT_CAP    = 40;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              status;
    } t_pkt_beat;

    logic i_clk;
    logic i_rst_n;

    cfcb_cmd_if cmd_ch ();
    cfcb_pkt_if pkt_ch ();

    command_frame_crc16_builder_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_pkt   (pkt_ch)
    );

    // ------------------------------------------------------------------------
    // Frame predictor state (mirrors the packet tracking of the block).
    // ------------------------------------------------------------------------
    logic [CRC_W-1:0]  fr_crc;
    logic [BYTE_W-1:0] fr_left;
    logic              fr_crc_on;
    logic              fr_open;

    t_pkt_beat pending_bytes[$];

    int mismatch_cnt;
    int items_sent;
    int cycle_cnt;

    // Sender burst shaping.
    int tx_burst_left;

    // ------------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt >= CYCLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Reflected CRC-16, poly 0x8408, one byte at a time.
    function automatic logic [CRC_W-1:0] crc16_mcrf_byte(input logic [CRC_W-1:0] crc,
                                                         input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    task automatic queue_beat(input logic [BYTE_W-1:0] d, input logic l, input logic s);
        t_pkt_beat bt;
        bt.data   = d;
        bt.last   = l;
        bt.status = s;
        pending_bytes.push_back(bt);
    endtask

    // Expected packet bytes caused by one accepted command request.
    task automatic build_frame_bytes(input logic [BYTE_W-1:0] b,
                                     input logic [BYTE_W-1:0] c,
                                     input logic [BYTE_W-1:0] l);
        logic [BYTE_W-1:0] hdr;
        if (!fr_open) begin
            // Bad length: a lone error byte, the command byte is dropped.
            if (l == 8'd0 || l > LEN_MAX) begin
                queue_beat(8'h00, 1'b1, ST_BAD_LEN);
                return;
            end
            fr_open   = 1'b1;
            fr_crc_on = c[CRC_EN_BIT];
            fr_left   = l;
            fr_crc    = crc16_mcrf_byte(CRC_INIT, MARKER_BYTE);
            queue_beat(MARKER_BYTE, 1'b0, ST_OK);
            hdr    = c | (l & HDR_LEN_MASK);
            fr_crc = crc16_mcrf_byte(fr_crc, hdr);
            queue_beat(hdr, 1'b0, ST_OK);
        end
        // Inside an open packet ctrl and length are ignored.
        fr_left = fr_left - 8'd1;
        fr_crc  = crc16_mcrf_byte(fr_crc, b);
        if (fr_left == 8'd0) begin
            queue_beat(b, !fr_crc_on, ST_OK);
            if (fr_crc_on) begin
                queue_beat(fr_crc[7:0], 1'b0, ST_OK);
                queue_beat(fr_crc[15:8], 1'b1, ST_OK);
            end
            fr_open   = 1'b0;
            fr_crc_on = 1'b0;
            fr_crc    = CRC_INIT;
        end else begin
            queue_beat(b, 1'b0, ST_OK);
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    // ------------------------------------------------------------------------
    // Command request: drive, hold until taken, predict, then maybe idle.
    // Called at a rising edge; valid stays high across back-to-back requests.
    // ------------------------------------------------------------------------
    task automatic send_cmd(input logic [BYTE_W-1:0] b,
                            input logic [BYTE_W-1:0] c,
                            input logic [BYTE_W-1:0] l);
        int gap;
        cmd_ch.valid      <= 1'b1;
        cmd_ch.cmd_byte   <= b;
        cmd_ch.ctrl       <= c;
        cmd_ch.cmd_length <= l;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        build_frame_bytes(b, c, l);
        items_sent++;

        tx_burst_left--;
        if (tx_burst_left <= 0) begin
            // Mostly short bursts; now and then a long stretch with no gaps.
            if ($urandom_range(0, 3) == 0) begin
                tx_burst_left = $urandom_range(20, 40);
            end else begin
                tx_burst_left = $urandom_range(1, 8);
            end
            gap = $urandom_range(1, 5);
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Packet sink: check every taken byte, then pick next ready.
    // The mode is redrawn at random among: always ready, rotating pattern,
    // mostly stalled, or coin flip.
    // ------------------------------------------------------------------------
    initial begin
        int        rx_mode;
        int        rx_cnt;
        logic [7:0] rx_pat;
        t_pkt_beat want;
        logic      rdy;

        rx_mode = 0;
        rx_cnt  = 0;
        rx_pat  = 8'b1011_0010;
        pkt_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pkt_ch.valid && pkt_ch.ready) begin
                if (pending_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h last %0b status %0b",
                                              pkt_ch.out_byte, pkt_ch.last,
                                              pkt_ch.status));
                end else begin
                    want = pending_bytes.pop_front();
                    if (pkt_ch.out_byte !== want.data || pkt_ch.last !== want.last ||
                        pkt_ch.status !== want.status) begin
                        report_mismatch($sformatf(
                            "got byte %02h last %0b status %0b, want %02h %0b %0b",
                            pkt_ch.out_byte, pkt_ch.last, pkt_ch.status,
                            want.data, want.last, want.status));
                    end
                end
            end

            rx_cnt++;
            if (rx_cnt % 48 == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_pat  = $urandom_range(1, 255);
            end
            case (rx_mode)
                0: rdy = 1'b1;
                1: begin
                    rdy    = rx_pat[0];
                    rx_pat = {rx_pat[0], rx_pat[7:1]};
                end
                2: rdy = ($urandom_range(0, 3) == 0);
                default: rdy = $urandom_range(0, 1);
            endcase
            pkt_ch.ready <= rdy;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Length 0 and several too-long lengths (LEN_MAX+1, 128, 255), each a single error byte.
    task automatic test_bad_lengths();
        send_cmd(8'hFF, 8'h40, 8'd0);
        send_cmd(8'h00, 8'hFF, LEN_MAX + 8'd1);
        send_cmd(8'hA5, 8'h00, 8'd255);
        send_cmd(8'h5A, 8'hC0, 8'd128);
    endtask

    // Whole packet from one request, with and without CRC trailer.
    task automatic test_single_byte();
        send_cmd(8'h00, 8'h40, 8'd1);
        send_cmd(8'hFF, 8'h00, 8'd1);
        send_cmd(8'h3C, 8'hFF, 8'd1);
        send_cmd(8'hC3, 8'hBF, 8'd1);
    endtask

    // Longest legal command; later bytes carry junk ctrl/length to be ignored.
    task automatic test_max_length();
        send_cmd(8'hFF, 8'h4F, LEN_MAX);
        for (int i = 1; i < LEN_MAX; i++) begin
            send_cmd((i % 2) ? 8'h00 : 8'hFF, 8'(i * 37), (i % 3) ? 8'd0 : 8'd255);
        end
    endtask

    // Two-byte command without CRC; the second byte ends the packet.
    task automatic test_short_plain();
        send_cmd(8'h81, 8'h20, 8'd2);
        send_cmd(8'h7E, 8'h40, 8'd0);
    endtask

    // Mostly well-formed commands of random content; some bad first bytes.
    task automatic test_random_frames();
        int               start;
        logic [BYTE_W-1:0] len;
        logic [BYTE_W-1:0] ctl;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0) begin
                len = ($urandom_range(0, 1) == 0) ? 8'd0 :
                      8'($urandom_range(int'(LEN_MAX) + 1, 255));
                send_cmd(8'($urandom), 8'($urandom), len);
            end else begin
                // Favor short commands so more packet boundaries are hit.
                if ($urandom_range(0, 1) == 0) begin
                    len = 8'($urandom_range(1, 3));
                end else begin
                    len = 8'($urandom_range(1, int'(LEN_MAX)));
                end
                ctl = 8'($urandom);
                send_cmd(8'($urandom), ctl, len);
                for (int i = 1; i < len; i++) begin
                    send_cmd(8'($urandom), 8'($urandom), 8'($urandom));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        mismatch_cnt  = 0;
        items_sent    = 0;
        tx_burst_left = 4;
        fr_crc        = CRC_INIT;
        fr_left       = 8'd0;
        fr_crc_on     = 1'b0;
        fr_open       = 1'b0;

        i_rst_n           <= 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.cmd_byte   <= 8'h00;
        cmd_ch.ctrl       <= 8'h00;
        cmd_ch.cmd_length <= 8'h00;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_bad_lengths();
        test_single_byte();
        test_max_length();
        test_short_plain();
        test_random_frames();

        cmd_ch.valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0 && pending_bytes.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/cfcb_pkg.sv
src/cfcb_cmd_if.sv
src/cfcb_pkt_if.sv
src/cfcb_front.sv
src/cfcb_queue.sv
src/cfcb_back.sv
src/command_frame_crc16_builder_top.sv
dv/command_frame_crc16_builder_top_tb.sv
